@@ src/blq_pkg.sv @@
// Shared constants and register codes for the beep level qualifier.
`default_nettype none
package blq_pkg;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LEVEL_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_BEEP_TICKS  = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_TOLERANCE_PCT   = 2'd2;

	localparam int unsigned TOL_BITS = 7;

	// register reset values, cut to the configured widths where used
	localparam logic [31:0] THRESHOLD_RESET = 32'd1000;
	localparam logic [31:0] MIN_TICKS_RESET = 32'd150;
	localparam logic [TOL_BITS-1:0] TOLERANCE_RESET = 7'd10;

	// full scale of the percent band
	localparam logic [TOL_BITS:0] PCT_FULL = 8'd100;

endpackage
`default_nettype wire

@@ src/beep_level_qualifier_core.sv @@
// Beep level qualifier: threshold, band-aware smoother, beep length and calibration phase.
// A word accepted into the input register reaches the result outputs once it moves on into the result register.
// Throughput: one word per cycle, each resolved in one pass between input and result registers.
// A stalled result holds the input register; otherwise a new word is taken every cycle.
// Reset (arst_n low, asynchronous): valids, phase, beep state and smoother clear to 0,
//   registers return to threshold 1000, minimum length 150, tolerance 10 percent.
`default_nettype none
module beep_level_qualifier_core #(
	parameter int unsigned LEVEL_BITS  = 15,
	parameter int unsigned LENGTH_BITS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [LEVEL_BITS-1:0]                mic_level,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic                                      phase,
	output logic                                      sounding,
	output logic [LEVEL_BITS-1:0]                     smoothed_level,
	output logic [LEVEL_BITS-1:0]                     peak_first_level,
	output logic [LEVEL_BITS-1:0]                     second_level,
	output logic                                      beep_ended,
	output logic [LENGTH_BITS-1:0]                    beep_ticks,
	output logic                                      calibrated,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [blq_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [((LENGTH_BITS > LEVEL_BITS) ? LENGTH_BITS : LEVEL_BITS)-1:0] cfg_data
);
	import blq_pkg::*;

	localparam int unsigned CMP_BITS   = LEVEL_BITS + 8;
	localparam int unsigned SUM5_BITS  = LEVEL_BITS + 3;
	localparam int unsigned DIV5_SHIFT = LEVEL_BITS + 6;
	localparam int unsigned DIV5_MUL   = (2 ** DIV5_SHIFT) / 5 + 1;
	localparam int unsigned PROD5_BITS = SUM5_BITS + DIV5_SHIFT;
	localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

	// configuration
	logic [LEVEL_BITS-1:0]  threshold_q;
	logic [LENGTH_BITS-1:0] min_ticks_q;
	logic [TOL_BITS-1:0]    lo_factor_q;
	logic [TOL_BITS:0]      hi_factor_q;
	logic [TOL_BITS-1:0]    tol_clamped;

	// handshake and input stage
	logic                  accept;
	logic                  advance;
	logic                  valid_s1;
	logic [LEVEL_BITS-1:0] level_s1;

	// block state
	logic                   phase_q;
	logic                   in_beep_q;
	logic [LENGTH_BITS-1:0] length_q;
	logic [LEVEL_BITS-1:0]  smoother_q;
	logic [LEVEL_BITS-1:0]  peak_q;
	logic [LEVEL_BITS-1:0]  second_q;

	// result register
	logic                   out_valid_q;
	logic                   phase_out_q;
	logic                   sounding_q;
	logic [LEVEL_BITS-1:0]  smoothed_q;
	logic [LEVEL_BITS-1:0]  peak_out_q;
	logic [LEVEL_BITS-1:0]  second_out_q;
	logic                   ended_q;
	logic [LENGTH_BITS-1:0] ticks_q;
	logic                   cal_q;

	// single-pass datapath
	logic                   snd;
	logic [LEVEL_BITS-1:0]  f_old;
	logic [CMP_BITS-1:0]    x_scaled;
	logic [CMP_BITS-1:0]    lo_prod;
	logic [CMP_BITS-1:0]    hi_prod;
	logic                   in_band;
	logic [SUM5_BITS-1:0]   sum5;
	logic [PROD5_BITS-1:0]  prod5;
	logic [LEVEL_BITS:0]    avg_sum;
	logic [LEVEL_BITS-1:0]  smooth_new;
	logic [LENGTH_BITS-1:0] length_new;
	logic                   ended;
	logic                   cal;

	assign cfg_ready = 1'b1;

	always_comb begin
		tol_clamped = (cfg_data[TOL_BITS-1:0] > PCT_FULL[TOL_BITS-1:0]) ?
			PCT_FULL[TOL_BITS-1:0] : cfg_data[TOL_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET[LEVEL_BITS-1:0];
			min_ticks_q <= MIN_TICKS_RESET[LENGTH_BITS-1:0];
			lo_factor_q <= PCT_FULL[TOL_BITS-1:0] - TOLERANCE_RESET;
			hi_factor_q <= PCT_FULL + {1'b0, TOLERANCE_RESET};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LEVEL_THRESHOLD: threshold_q <= cfg_data[LEVEL_BITS-1:0];
				CFG_MIN_BEEP_TICKS:  min_ticks_q <= cfg_data[LENGTH_BITS-1:0];
				CFG_TOLERANCE_PCT: begin
					// band factors are kept ready-made: 100 - tol and 100 + tol
					lo_factor_q <= PCT_FULL[TOL_BITS-1:0] - tol_clamped;
					hi_factor_q <= PCT_FULL + {1'b0, tol_clamped};
				end
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			level_s1 <= mic_level;
		end
	end

	always_comb begin
		snd   = level_s1 > threshold_q;
		// a new beep starts the smoother from zero
		f_old = in_beep_q ? smoother_q : '0;

		// floor(f*lo/100) <= x  <=>  f*lo <= 100x + 99 ; x <= floor(f*hi/100) <=> 100x <= f*hi
		x_scaled = CMP_BITS'(level_s1) * CMP_BITS'(PCT_FULL);
		lo_prod  = CMP_BITS'(f_old) * CMP_BITS'(lo_factor_q);
		hi_prod  = CMP_BITS'(f_old) * CMP_BITS'(hi_factor_q);
		in_band  = (lo_prod <= x_scaled + CMP_BITS'(PCT_FULL - 8'd1)) && (x_scaled <= hi_prod);

		// divide by five through a reciprocal multiply, exact over the sum range
		sum5  = SUM5_BITS'(level_s1) + {1'b0, f_old, 2'b00};
		prod5 = PROD5_BITS'(sum5) * PROD5_BITS'(DIV5_MUL);

		avg_sum = {1'b0, f_old} + {1'b0, level_s1};

		smooth_new = in_band ? prod5[DIV5_SHIFT +: LEVEL_BITS] : avg_sum[LEVEL_BITS:1];

		if (!in_beep_q) begin
			length_new = LENGTH_BITS'(1);
		end else if (length_q != LENGTH_MAX) begin
			length_new = length_q + LENGTH_BITS'(1);
		end else begin
			length_new = length_q;
		end

		ended = !snd && in_beep_q;
		cal   = ended && !phase_q && (length_q >= min_ticks_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= 1'b0;
			in_beep_q  <= 1'b0;
			length_q   <= '0;
			smoother_q <= '0;
			peak_q     <= '0;
			second_q   <= '0;
		end else if (advance) begin
			if (snd) begin
				in_beep_q  <= 1'b1;
				length_q   <= length_new;
				smoother_q <= smooth_new;
				if (!phase_q) begin
					if (smooth_new > peak_q) begin
						peak_q <= smooth_new;
					end
				end else begin
					second_q <= smooth_new;
				end
			end else begin
				in_beep_q <= 1'b0;
				if (cal) begin
					phase_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= advance || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			phase_out_q  <= phase_q || cal;
			sounding_q   <= snd;
			smoothed_q   <= snd ? smooth_new : smoother_q;
			peak_out_q   <= (snd && !phase_q && (smooth_new > peak_q)) ? smooth_new : peak_q;
			second_out_q <= (snd && phase_q) ? smooth_new : second_q;
			ended_q      <= ended;
			ticks_q      <= ended ? length_q : '0;
			cal_q        <= cal;
		end
	end

	assign out_valid        = out_valid_q;
	assign phase            = phase_out_q;
	assign sounding         = sounding_q;
	assign smoothed_level   = smoothed_q;
	assign peak_first_level = peak_out_q;
	assign second_level     = second_out_q;
	assign beep_ended       = ended_q;
	assign beep_ticks       = ticks_q;
	assign calibrated       = cal_q;

	// calibration only closes a beep and always lands in the second phase
	a_cal_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && calibrated |-> beep_ended && phase)
		else $error("calibrated without a closing beep");

	// the second phase is final until reset
	a_phase_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(phase_q))
		else $error("phase left the second phase");

	// a beep in progress has a nonzero length
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		in_beep_q |-> length_q != '0)
		else $error("beep in progress with zero length");

	// input holds off only behind a blocked full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

endmodule
`default_nettype wire
